### design/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// Types, constants and helpers shared by the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

    localparam int VALUE_W      = 32;
    localparam int NUM_DIGITS   = 10;
    localparam int DIGIT_CNT_W  = 4;
    localparam int BIT_CNT_W    = $clog2(VALUE_W);
    localparam int BCD_W        = NUM_DIGITS * 4;
    localparam int CAP_W        = 7;
    localparam int WIDTH_W      = 6;
    localparam int POS_W        = 7;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 7;
    localparam int MAX_CAPACITY = 64;
    localparam int FIELD_LIMIT  = 63;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [7:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUMBER_BASE   = 3'd0,
        CFG_FIELD_WIDTH   = 3'd1,
        CFG_PAD_WITH_ZERO = 3'd2,
        CFG_HEX_PREFIX    = 3'd3,
        CFG_CAPACITY      = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_PLAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               op;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         character;
        logic               last;
        logic               error;
        logic [WIDTH_W-1:0] length;
    } t_out_item;

    typedef struct packed {
        logic               number_base;
        logic [WIDTH_W-1:0] field_width;
        logic               pad_with_zero;
        logic               hex_prefix;
        logic [CAP_W-1:0]   capacity;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic step;
        logic norm;
        logic shift_digit;
    } t_conv_ctrl;

    typedef struct packed {
        logic                   conv_last;
        logic                   norm_done;
        logic [DIGIT_CNT_W-1:0] num_digits;
        logic [3:0]             top_digit;
    } t_conv_status;

    typedef struct packed {
        logic plan;
        logic run;
    } t_emit_ctrl;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return DIGIT_CHARS[d];
    endfunction

endpackage

### design/ita_conv.sv
// ----------------------------------------------------------------------------
// ita_conv
// Bit-serial binary to digit conversion: shift-add-3 for decimal, plain
// shift for hex, then a nibble-wide normalise that drops leading zeros.
// ----------------------------------------------------------------------------
module ita_conv import ita_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_conv_ctrl         i_ctrl,
    input  logic [VALUE_W-1:0] i_mag,
    input  logic               i_decimal,
    output t_conv_status       o_status
);

    logic [VALUE_W-1:0]     r_mag, n_mag;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [BIT_CNT_W-1:0]   r_cnt, n_cnt;
    logic [DIGIT_CNT_W-1:0] r_nd, n_nd;
    logic                   r_dec, n_dec;
    logic [BCD_W-1:0]       adj;
    logic                   top_zero;

    // in decimal mode, add 3 to every digit of five or more before the shift
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (r_dec && r_bcd[k*4 +: 4] >= 4'd5) begin
                adj[k*4 +: 4] = r_bcd[k*4 +: 4] + 4'd3;
            end else begin
                adj[k*4 +: 4] = r_bcd[k*4 +: 4];
            end
        end
    end

    assign top_zero = (r_bcd[BCD_W-1 -: 4] == 4'd0);

    always_comb begin
        n_mag = r_mag;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        n_nd  = r_nd;
        n_dec = r_dec;
        if (i_ctrl.load) begin
            n_mag = i_mag;
            n_bcd = '0;
            n_cnt = '0;
            n_nd  = DIGIT_CNT_W'(NUM_DIGITS);
            n_dec = i_decimal;
        end else if (i_ctrl.step) begin
            n_bcd = {adj[BCD_W-2:0], r_mag[VALUE_W-1]};
            n_mag = {r_mag[VALUE_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
        end else if (i_ctrl.norm) begin
            if (top_zero && r_nd > DIGIT_CNT_W'(1)) begin
                n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                n_nd  = r_nd - 1'b1;
            end
        end else if (i_ctrl.shift_digit) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_bcd <= n_bcd;
        r_nd  <= n_nd;
        r_dec <= n_dec;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_status.conv_last  = i_ctrl.step && (r_cnt == {BIT_CNT_W{1'b1}});
    assign o_status.norm_done  = !top_zero || (r_nd == DIGIT_CNT_W'(1));
    assign o_status.num_digits = r_nd;
    assign o_status.top_digit  = r_bcd[BCD_W-1 -: 4];

endmodule

### design/ita_emit.sv
// ----------------------------------------------------------------------------
// ita_emit
// Field layout and character sequencer: works out padding, prefix and sign
// boundaries once per item, then emits one character per free output slot.
// ----------------------------------------------------------------------------
module ita_emit import ita_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_emit_ctrl             i_ctrl,
    input  t_cfg                   i_cfg,
    input  logic                   i_op,
    input  logic                   i_neg,
    input  logic [DIGIT_CNT_W-1:0] i_num_digits,
    input  logic [3:0]             i_top_digit,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output t_out_item              o_out_item,
    output logic                   o_shift_digit,
    output logic                   o_done
);

    logic [POS_W-1:0] r_b1, r_b2, r_b3, r_b4, r_total, r_idx;
    logic [POS_W-1:0] n_b1, n_b2, n_b3, n_b4, n_total, n_idx;
    logic             r_err, n_err;
    logic             r_valid, n_valid;
    t_out_item        r_item, n_item;

    logic [POS_W-1:0] sign_chars, ns, pad, pre, total, cap;
    logic             err, load, is_last;
    logic [7:0]       ch;

    // layout of the field for the item in hand
    always_comb begin
        sign_chars = {{(POS_W-1){1'b0}}, i_neg};
        ns       = POS_W'(i_num_digits) + sign_chars;
        pad      = (POS_W'(i_cfg.field_width) > ns) ? POS_W'(i_cfg.field_width) - ns : '0;
        pre      = (!i_op && i_cfg.number_base && i_cfg.hex_prefix &&
                    i_cfg.field_width != '0) ? POS_W'(2) : '0;
        total    = pad + pre + ns;
        cap      = (i_cfg.capacity > CAP_W'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY)
                                                            : i_cfg.capacity;
        err      = (cap < CAP_W'(2)) || (total >= POS_W'(cap)) ||
                   (total > POS_W'(FIELD_LIMIT));
    end

    assign load    = i_ctrl.run && (!r_valid || !i_out_stall);
    assign is_last = (r_idx + 1'b1 == r_total);

    always_comb begin
        if (r_idx < r_b1) begin
            ch = CH_SPACE;
        end else if (r_idx < r_b2) begin
            ch = (r_idx == r_b1) ? CH_ZERO : CH_X;
        end else if (r_idx < r_b3) begin
            ch = CH_MINUS;
        end else if (r_idx < r_b4) begin
            ch = CH_ZERO;
        end else begin
            ch = digit_char(i_top_digit);
        end
    end

    always_comb begin
        n_b1    = r_b1;
        n_b2    = r_b2;
        n_b3    = r_b3;
        n_b4    = r_b4;
        n_total = r_total;
        n_err   = r_err;
        n_idx   = r_idx;
        n_item  = r_item;
        n_valid = r_valid && i_out_stall;
        if (i_ctrl.plan) begin
            n_b1    = i_cfg.pad_with_zero ? '0 : pad;
            n_b2    = n_b1 + pre;
            n_b3    = n_b2 + sign_chars;
            n_b4    = n_b3 + (i_cfg.pad_with_zero ? pad : '0);
            n_total = total;
            n_err   = err;
            n_idx   = '0;
        end
        if (load) begin
            n_valid = 1'b1;
            if (r_err) begin
                n_item = '{character: CH_NUL, last: 1'b1, error: 1'b1, length: '0};
            end else begin
                n_item.character = ch;
                n_item.last      = is_last;
                n_item.error     = 1'b0;
                n_item.length    = is_last ? r_total[WIDTH_W-1:0] : '0;
                n_idx            = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1    <= n_b1;
        r_b2    <= n_b2;
        r_b3    <= n_b3;
        r_b4    <= n_b4;
        r_total <= n_total;
        r_err   <= n_err;
        r_idx   <= n_idx;
        r_item  <= n_item;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_shift_digit = load && !r_err && (r_idx >= r_b4);
    assign o_done        = load && (r_err || is_last);
    assign o_out_valid   = r_valid;
    assign o_out_item    = r_item;

endmodule

### design/int_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// int_to_ascii_formatter
// Formats a 32-bit value as signed decimal or unsigned decimal/hex ASCII,
// with optional padding and 0x prefix, one character per result item.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  input    | i_in_valid, o_in_stall, i_in_item        | item in
//  output   | o_out_valid, i_out_stall, o_out_item     | characters out
//  config   | i_cfg_wr_en, i_cfg_index, i_cfg_data     | register writes
//
//  One item at a time: an accept state, bit-serial conversion, leading-zero
//  removal in the nibble normaliser, a layout state, then one character per
//  free output slot, 1 to 63 characters per item. Reset is synchronous and
//  active low; the config registers return to capacity 64 and their other
//  fields to 0. A stall on the output holds the character sequencer. The
//  next item is taken while the final character still waits.
// ----------------------------------------------------------------------------
module int_to_ascii_formatter import ita_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state       r_state, n_state;
    t_cfg         r_cfg;
    logic         r_op, r_neg;
    logic         accept;
    logic         neg_in;
    logic [VALUE_W-1:0] mag_in;
    t_conv_ctrl   conv_ctrl;
    t_conv_status conv_status;
    t_emit_ctrl   emit_ctrl;
    logic         shift_digit;
    logic         emit_done;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign neg_in     = i_in_item.op && i_in_item.value[VALUE_W-1];
    assign mag_in     = neg_in ? (~i_in_item.value + 1'b1) : i_in_item.value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{number_base: 1'b0, field_width: '0, pad_with_zero: 1'b0,
                       hex_prefix: 1'b0, capacity: CAP_W'(MAX_CAPACITY)};
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NUMBER_BASE:   r_cfg.number_base   <= i_cfg_data[0];
                CFG_FIELD_WIDTH:   r_cfg.field_width   <= i_cfg_data[WIDTH_W-1:0];
                CFG_PAD_WITH_ZERO: r_cfg.pad_with_zero <= i_cfg_data[0];
                CFG_HEX_PREFIX:    r_cfg.hex_prefix    <= i_cfg_data[0];
                CFG_CAPACITY:      r_cfg.capacity      <= i_cfg_data[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_in_item.op;
            r_neg <= neg_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        conv_ctrl = '0;
        emit_ctrl = '0;
        conv_ctrl.shift_digit = shift_digit;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    conv_ctrl.load = 1'b1;
                    n_state        = ST_CONV;
                end
            end
            ST_CONV: begin
                conv_ctrl.step = 1'b1;
                if (conv_status.conv_last) begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                conv_ctrl.norm = 1'b1;
                if (conv_status.norm_done) begin
                    n_state = ST_PLAN;
                end
            end
            ST_PLAN: begin
                emit_ctrl.plan = 1'b1;
                n_state        = ST_EMIT;
            end
            ST_EMIT: begin
                emit_ctrl.run = 1'b1;
                if (emit_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    ita_conv u_conv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (conv_ctrl),
        .i_mag     (mag_in),
        .i_decimal (i_in_item.op || !r_cfg.number_base),
        .o_status  (conv_status)
    );

    ita_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (emit_ctrl),
        .i_cfg         (r_cfg),
        .i_op          (r_op),
        .i_neg         (r_neg),
        .i_num_digits  (conv_status.num_digits),
        .i_top_digit   (conv_status.top_digit),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_item    (o_out_item),
        .o_shift_digit (shift_digit),
        .o_done        (emit_done)
    );

`ifndef SYNTH
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.error |-> o_out_item.last && o_out_item.length == '0)
        else $error("error result is not a lone last item");

    a_mid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last |-> o_out_item.length == '0 && !o_out_item.error)
        else $error("non-final item carries length or error");

    a_last_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last && !o_out_item.error |-> o_out_item.length != '0)
        else $error("final character has zero length");

    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PLAN |-> conv_status.num_digits != '0 &&
                               conv_status.num_digits <= DIGIT_CNT_W'(NUM_DIGITS))
        else $error("digit count out of range after normalise");
`endif

endmodule
